>>> design/sine_taylor_approximation_macros.svh
// Assertion helpers for the sine block.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef SINE_TAYLOR_APPROXIMATION_MACROS_SVH
`define SINE_TAYLOR_APPROXIMATION_MACROS_SVH

// Same-cycle implication.
`define STA_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define STA_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> design/sta_pkg.sv
package sta_pkg;

	// Range reduction constants
	localparam logic [29:0]        InvTwoPiQ32 = 30'd683565276;
	localparam logic [31:0]        TwoPiQ29    = 32'd3373259426;
	localparam logic signed [32:0] PiQ28       = 33'sd843314857;
	localparam logic signed [32:0] TwoPiQ28    = 33'sd1686629713;

	// Taylor coefficients, Q.28
	localparam logic [31:0]        Coef9Q28 = 32'd740;
	localparam logic signed [31:0] Coef7Q28 = -32'sd53261;
	localparam logic signed [31:0] Coef5Q28 = 32'sd2236962;
	localparam logic signed [31:0] Coef3Q28 = -32'sd44739243;
	localparam logic signed [31:0] OneQ28   = 32'sd268435456;

	// Output clamp
	localparam logic signed [36:0] SatHi = 37'sd2147483647;
	localparam logic signed [36:0] SatLo = -37'sd2147483648;

	// Bound on |sine| in Q2.30 (degree-9 error at pi is well under 1%)
	localparam logic signed [31:0] SineBound = 32'sd1090000000;

	localparam logic [4:0] ShQ28 = 5'd28;
	localparam logic [4:0] ShQ30 = 5'd26;

	typedef struct packed {
		logic signed [31:0] angle;
		logic               last_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sine;
		logic               last_out;
	} out_t;

	// Horner stage payload
	typedef struct packed {
		logic [31:0]        y;
		logic signed [31:0] x;
		logic signed [31:0] z;
		logic               last;
	} hrn_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		return v[31] ? n : v;
	endfunction

	// Magnitude product, rounded half up at bit sh, then signed.
	function automatic logic signed [36:0] mul_round(input logic [31:0] mag_a,
			input logic [31:0] mag_b, input logic neg, input logic [4:0] sh);
		logic [63:0]        p;
		logic [64:0]        sum;
		logic [36:0]        mag_p;
		logic signed [36:0] res;
		p     = 64'(mag_a) * 64'(mag_b);
		sum   = 65'(p) + (65'd1 << (sh - 5'd1));
		mag_p = 37'(sum >> sh);
		res   = $signed(mag_p);
		return neg ? -res : res;
	endfunction

endpackage

>>> design/sta_horner_step.sv
// One Horner step: z' = round(y * (z + coef)) in Q.28, one register stage.
module sta_horner_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] coef,
	input  logic               up_valid,
	output logic               up_ready,
	input  sta_pkg::hrn_t      up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output sta_pkg::hrn_t      dn_data
);

	logic               valid_q;
	sta_pkg::hrn_t      data_q;
	logic signed [31:0] w;
	logic signed [36:0] prod;

	assign w    = up_data.z + coef;
	// y is never negative, so the sign comes from w alone
	assign prod = sta_pkg::mul_round(up_data.y, sta_pkg::mag32(w), w[31], sta_pkg::ShQ28);

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.y    <= up_data.y;
			data_q.x    <= up_data.x;
			data_q.z    <= prod[31:0];
			data_q.last <= up_data.last;
		end
	end

endmodule

>>> design/sine_taylor_approximation.sv
// Fixed-point sine. Each transaction carries one angle in signed Q8.24 radians and
// returns its sine in signed Q2.30, with the last flag copied alongside. The angle is
// folded to one turn (multiply by 1/(2pi), keep the fraction truncated toward zero,
// multiply by 2pi, one conditional add of +-2pi into [-pi, pi]) and then run through
// the odd degree-9 Taylor polynomial in Horner form. The block takes one transaction
// per clock when the output is not stalled. The rate is set by a ten-stage pipeline with
// at most one 32x32 multiplier per stage; each stage moves on when it is empty or its
// successor moves, so bubbles are squeezed out and input is still accepted while a result
// waits at the output, as long as some stage is empty.
// Results leave in arrival order.
`include "sine_taylor_approximation_macros.svh"

module sine_taylor_approximation (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          angle_valid,
	output logic          angle_stall,
	input  sta_pkg::in_t  angle_data,
	output logic          sine_valid,
	input  logic          sine_stall,
	output sta_pkg::out_t sine_data
);

	// per-stage advance: stage k loads when empty or when stage k+1 loads
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy10;

	// s1: sign and magnitude of the angle
	logic               valid_s1;
	logic               neg_s1;
	logic [31:0]        mag_s1;
	logic               last_s1;
	// s2: fraction of a turn, Q0.32
	logic               valid_s2;
	logic               neg_s2;
	logic [31:0]        frac_s2;
	logic               last_s2;
	// s3: fraction back in radians, Q.28 magnitude
	logic               valid_s3;
	logic               neg_s3;
	logic [30:0]        rmag_s3;
	logic               last_s3;
	// s4: reduced angle in [-pi, pi]
	logic               valid_s4;
	logic signed [31:0] x_s4;
	logic               last_s4;
	// s5: y = x^2
	logic               valid_s5;
	logic signed [31:0] x_s5;
	logic [31:0]        y_s5;
	logic               last_s5;
	// s6: first Horner product
	logic               valid_s6;
	sta_pkg::hrn_t      h_s6;
	// s7..s9 live in the Horner step instances
	logic               valid7, valid8, valid9;
	sta_pkg::hrn_t      h7, h8, h9;
	// s10: final product, saturated; this is the output register
	logic               valid_s10;
	sta_pkg::out_t      out_s10;

	// combinational results per stage
	logic [63:0]        turns;
	logic [63:0]        rprod;
	logic [64:0]        rsum;
	logic signed [32:0] xs;
	logic signed [32:0] xr;
	logic signed [36:0] ysq;
	logic signed [36:0] z9;
	logic signed [31:0] wf;
	logic signed [36:0] sf;
	logic signed [31:0] sat;

	// terms for the checks at the end
	logic               x_in_range;
	logic               sine_in_bound;
	logic               pipe_full;

	assign rdy10 = !valid_s10 || !sine_stall;
	assign rdy6  = !valid_s6 || rdy7;
	assign rdy5  = !valid_s5 || rdy6;
	assign rdy4  = !valid_s4 || rdy5;
	assign rdy3  = !valid_s3 || rdy4;
	assign rdy2  = !valid_s2 || rdy3;
	assign rdy1  = !valid_s1 || rdy2;

	assign angle_stall = !rdy1;
	assign sine_valid  = valid_s10;
	assign sine_data   = out_s10;

	// turns in Q.56; the fraction sits in bits 55:24 after truncation to Q0.32
	assign turns = 64'(mag_s1) * 64'(sta_pkg::InvTwoPiQ32);

	// frac * 2pi (Q3.29) rounded half up to Q.28
	assign rprod = 64'(frac_s2) * 64'(sta_pkg::TwoPiQ29);
	assign rsum  = 65'(rprod) + (65'd1 << 32);

	// sign back on, then at most one wrap by 2pi; exactly +-pi stays put
	always_comb begin
		xs = neg_s3 ? -$signed({2'b00, rmag_s3}) : $signed({2'b00, rmag_s3});
		if (xs > sta_pkg::PiQ28) begin
			xr = xs - sta_pkg::TwoPiQ28;
		end else if (xs < -sta_pkg::PiQ28) begin
			xr = xs + sta_pkg::TwoPiQ28;
		end else begin
			xr = xs;
		end
	end

	assign ysq = sta_pkg::mul_round(sta_pkg::mag32(x_s4), sta_pkg::mag32(x_s4), 1'b0,
		sta_pkg::ShQ28);
	assign z9  = sta_pkg::mul_round(y_s5, sta_pkg::Coef9Q28, 1'b0, sta_pkg::ShQ28);

	// x * (z + 1) to Q.30, then clamp to 32 bits
	assign wf = h9.z + sta_pkg::OneQ28;
	assign sf = sta_pkg::mul_round(sta_pkg::mag32(h9.x), sta_pkg::mag32(wf),
		h9.x[31] ^ wf[31], sta_pkg::ShQ30);

	always_comb begin
		if (sf > sta_pkg::SatHi) begin
			sat = sta_pkg::SatHi[31:0];
		end else if (sf < sta_pkg::SatLo) begin
			sat = sta_pkg::SatLo[31:0];
		end else begin
			sat = sf[31:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			if (rdy1)  valid_s1  <= angle_valid;
			if (rdy2)  valid_s2  <= valid_s1;
			if (rdy3)  valid_s3  <= valid_s2;
			if (rdy4)  valid_s4  <= valid_s3;
			if (rdy5)  valid_s5  <= valid_s4;
			if (rdy6)  valid_s6  <= valid_s5;
			if (rdy10) valid_s10 <= valid9;
		end
	end

	// payload, loaded only when a transaction moves in
	always_ff @(posedge clk) begin
		if (rdy1 && angle_valid) begin
			neg_s1  <= angle_data.angle[31];
			mag_s1  <= sta_pkg::mag32(angle_data.angle);
			last_s1 <= angle_data.last_in;
		end
		if (rdy2 && valid_s1) begin
			neg_s2  <= neg_s1;
			frac_s2 <= turns[55:24];
			last_s2 <= last_s1;
		end
		if (rdy3 && valid_s2) begin
			neg_s3  <= neg_s2;
			rmag_s3 <= rsum[63:33];
			last_s3 <= last_s2;
		end
		if (rdy4 && valid_s3) begin
			x_s4    <= xr[31:0];
			last_s4 <= last_s3;
		end
		if (rdy5 && valid_s4) begin
			x_s5    <= x_s4;
			y_s5    <= ysq[31:0];
			last_s5 <= last_s4;
		end
		if (rdy6 && valid_s5) begin
			h_s6.y    <= y_s5;
			h_s6.x    <= x_s5;
			h_s6.z    <= z9[31:0];
			h_s6.last <= last_s5;
		end
		if (rdy10 && valid9) begin
			out_s10.sine     <= sat;
			out_s10.last_out <= h9.last;
		end
	end

	// remaining Horner steps: -1/5040, 1/120, -1/6
	sta_horner_step u_step7 (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (sta_pkg::Coef7Q28),
		.up_valid (valid_s6),
		.up_ready (rdy7),
		.up_data  (h_s6),
		.dn_valid (valid7),
		.dn_ready (rdy8),
		.dn_data  (h7)
	);

	sta_horner_step u_step5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (sta_pkg::Coef5Q28),
		.up_valid (valid7),
		.up_ready (rdy8),
		.up_data  (h7),
		.dn_valid (valid8),
		.dn_ready (rdy9),
		.dn_data  (h8)
	);

	sta_horner_step u_step3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (sta_pkg::Coef3Q28),
		.up_valid (valid8),
		.up_ready (rdy9),
		.up_data  (h8),
		.dn_valid (valid9),
		.dn_ready (rdy10),
		.dn_data  (h9)
	);

	assign x_in_range    = (x_s4 <= sta_pkg::PiQ28) && (x_s4 >= -sta_pkg::PiQ28);
	assign sine_in_bound = (sine_data.sine <= sta_pkg::SineBound) &&
		(sine_data.sine >= -sta_pkg::SineBound);
	assign pipe_full     = valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 &&
		valid_s6 && valid7 && valid8 && valid9 && valid_s10;

	// reduction must land inside [-pi, pi]
	`STA_CHECK(a_reduced_range, valid_s4, x_in_range)

	// a reduced angle never drives the polynomial into saturation
	`STA_CHECK(a_sine_bound, sine_valid, sine_in_bound)

	// input is pushed back only when every stage is occupied
	`STA_CHECK(a_stall_full, angle_stall, pipe_full)

	// an unstalled output leaves room for new input in the same cycle
	`STA_CHECK(a_drain_opens, !sine_stall, !angle_stall)

	// a stalled result stays put until it is taken
	`STA_CHECK_NEXT(a_out_hold, sine_valid && sine_stall, sine_valid && $stable(sine_data))

endmodule

>>> verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point constants of the sine datapath, kept local to the testbench.
	// Turn scaling is unsigned Q0.32, radian scaling unsigned Q3.29, the sine
	// limits signed Q2.30, and the rest is signed Q.28.
	localparam longint TurnPerRadQ32 = 64'sd683565276;
	localparam longint RadPerTurnQ29 = 64'sd3373259426;
	localparam longint HalfTurnQ28   = 64'sd843314857;
	localparam longint FullTurnQ28   = 64'sd1686629713;
	localparam longint Taylor9Q28    = 64'sd740;
	localparam longint Taylor7Q28    = -64'sd53261;
	localparam longint Taylor5Q28    = 64'sd2236962;
	localparam longint Taylor3Q28    = -64'sd44739243;
	localparam longint UnityQ28      = 64'sd268435456;
	localparam longint SineMaxQ30    = 64'sd2147483647;
	localparam longint SineMinQ30    = -64'sd2147483648;

	// pi in Q8.24 radians, used to aim angles at the fold points
	localparam int PiQ24 = 52707179;

	localparam int RandomAngles = 400;
	localparam int DrainCycles  = 20;     // extra wait after the drain; pipeline is 10 deep
	localparam int CycleLimit   = 200000; // upper bound for the whole run

	// Prediction for one accepted transaction, kept with the stimulus for messages
	typedef struct {
		sta_pkg::in_t  stim;
		sta_pkg::out_t want;
	} sine_expect_t;

	class sine_scoreboard;
		sine_expect_t sine_q[$];
		int           mismatches;
		int           sines_checked;

		task report(string what);
			$display("ERROR @%0t: %s", $time, what);
			mismatches++;
		endtask

		// Product of two signed values shifted down by sh, rounded to nearest,
		// ties away from zero.
		function longint round_mul(longint a, longint b, int sh);
			bit         neg;
			bit [63:0]  ua;
			bit [63:0]  ub;
			bit [63:0]  p;
			neg = (a < 0) != (b < 0);
			ua  = (a < 0) ? 64'(-a) : 64'(a);
			ub  = (b < 0) ? 64'(-b) : 64'(b);
			p   = (ua * ub + (64'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(p) : longint'(p);
		endfunction

		function sta_pkg::out_t sine_of(sta_pkg::in_t item);
			bit            neg;
			bit [31:0]     mag;
			bit [63:0]     turns;
			bit [31:0]     frac;
			bit [63:0]     rad;
			longint        x;
			longint        y;
			longint        z;
			longint        s;
			sta_pkg::out_t res;
			neg = item.angle[31];
			mag = neg ? (~item.angle + 32'd1) : item.angle;
			// keep only the fraction of a turn, magnitude truncated to Q0.32
			turns = 64'(mag) * 64'(TurnPerRadQ32);
			frac  = turns[55:24];
			// back to radians in Q.28, rounded half up, sign restored
			rad = (64'(frac) * 64'(RadPerTurnQ29) + (64'd1 << 32)) >> 33;
			x   = neg ? -longint'(rad) : longint'(rad);
			if (x > HalfTurnQ28) x -= FullTurnQ28;
			if (x < -HalfTurnQ28) x += FullTurnQ28;
			// odd Taylor series in Horner form over x^2
			y = round_mul(x, x, 28);
			z = round_mul(y, Taylor9Q28, 28);
			z = round_mul(y, z + Taylor7Q28, 28);
			z = round_mul(y, z + Taylor5Q28, 28);
			z = round_mul(y, z + Taylor3Q28, 28);
			s = round_mul(x, z + UnityQ28, 26);
			if (s > SineMaxQ30) s = SineMaxQ30;
			if (s < SineMinQ30) s = SineMinQ30;
			res.sine     = s[31:0];
			res.last_out = item.last_in;
			return res;
		endfunction

		function void note_angle(sta_pkg::in_t item);
			sine_expect_t e;
			e.stim = item;
			e.want = sine_of(item);
			sine_q.push_back(e);
		endfunction

		task check_sine(sta_pkg::out_t got);
			sine_expect_t e;
			if (sine_q.size() == 0) begin
				report($sformatf("unexpected result sine=%h last=%b", got.sine, got.last_out));
			end else begin
				e = sine_q.pop_front();
				sines_checked++;
				if (got.sine !== e.want.sine)
					report($sformatf("angle %h: sine %h, predicted %h",
						e.stim.angle, got.sine, e.want.sine));
				if (got.last_out !== e.want.last_out)
					report($sformatf("angle %h: last %b, predicted %b",
						e.stim.angle, got.last_out, e.want.last_out));
			end
		endtask

		function int pending();
			return sine_q.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          angle_valid;
	logic          angle_stall;
	sta_pkg::in_t  angle_data;
	logic          sine_valid;
	logic          sine_stall;
	sta_pkg::out_t sine_data;

	sine_scoreboard sb;
	bit             idle_on;      // random gaps and stalls allowed in this phase
	int             angles_sent;
	int             corner_count;
	int             cycle_count;

	sine_taylor_approximation DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.angle_data  (angle_data),
		.sine_valid  (sine_valid),
		.sine_stall  (sine_stall),
		.sine_data   (sine_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		cycle_count = 0;
		wait (cycle_count >= CycleLimit);
		$display("timeout after %0d cycles, %0d results still outstanding",
			cycle_count, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Monitor: both channels are sampled at the rising edge, before the DUT's
	// own updates land. Every accepted angle queues its predicted sine, and
	// every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (angle_valid && !angle_stall)
				sb.note_angle(angle_data);
			if (sine_valid === 1'b1 && !sine_stall)
				sb.check_sine(sine_data);
		end
	end

	// Output backpressure: bursts of stall separated by stretches of free flow, each
	// drawn at random, switched off entirely when idle_on is low.
	initial begin : stall_gen
		int hold;
		hold       = 0;
		sine_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				sine_stall <= 1'b0;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (sine_stall) begin
				sine_stall <= 1'b0;
				hold = $urandom_range(0, 20);
			end else if ($urandom_range(0, 3) == 0) begin
				sine_stall <= 1'b1;
				hold = $urandom_range(0, 13);
			end
		end
	end

	// Present one angle and hold it until the DUT takes it. When idling is on,
	// valid may first drop for a gap of random length.
	task automatic send_angle(logic [31:0] angle, logic last);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			@(negedge clk);
			angle_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		angle_valid      <= 1'b1;
		angle_data.angle <= angle;
		angle_data.last_in <= last;
		forever begin
			@(posedge clk);
			if (!angle_stall) break;
		end
		angles_sent++;
	endtask

	// Drop valid and wait until every queued sine has come back.
	task automatic drain_results();
		@(negedge clk);
		angle_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Random angle: a mix of full-range values, small angles within two
	// turns either way, angles just around a multiple of pi (where the fold decides),
	// and large magnitudes near the ends of the Q8.24 range.
	function automatic logic [31:0] pick_angle();
		int          k;
		int          base;
		logic [31:0] r;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 8 * PiQ24) - 4 * PiQ24;
			2: begin
				k    = $urandom_range(0, 40);
				base = k * PiQ24 + $urandom_range(0, 64) - 32;
				return ($urandom_range(0, 1) != 0) ? -base : base;
			end
			default: begin
				r = $urandom;
				return r[31] ? (r & 32'h81FFFFFF) : (r | 32'h7E000000);
			end
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] corners [20];
		int          i;
		sb           = new;
		arst_n       = 1'b0;
		angle_valid  = 1'b0;
		angle_data   = '0;
		idle_on      = 1'b1;
		angles_sent  = 0;
		// Corner angles: zero (no fraction left), +-1 lsb, both range ends
		// including -128.0, quarter/half/three-quarter/full turns on both
		// sides, one lsb either side of pi, whole radians and bit patterns.
		corners = '{32'd0, 32'd1, -32'sd1, 32'h7FFFFFFF, 32'h80000000,
			32'd26353589, -32'sd26353589, 32'd52707179, -32'sd52707179,
			32'd52707178, 32'd52707180, 32'd79060768, -32'sd79060768,
			32'd105414357, -32'sd105414357, 32'h01000000, 32'hFF000000,
			32'h55555555, 32'hAAAAAAAA, 32'h00FFFFFF};
		corner_count = $size(corners);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part; the last flag is set on every other corner
		foreach (corners[j])
			send_angle(corners[j], j[0]);

		// Full quiet: nothing in flight before random traffic starts
		drain_results();

		// Random part: idling on, then a quiet stretch, then idling again,
		// and a final stretch with neither gaps nor stalls.
		for (i = 0; i < RandomAngles; i++) begin
			idle_on = (i < 150) || (i >= 210 && i < 330);
			send_angle(pick_angle(), $urandom_range(0, 15) == 0);
		end

		drain_results();
		repeat (DrainCycles) @(negedge clk);

		$display("%0d angles sent (%0d corner cases, the rest random over the full Q8.24 range",
			angles_sent, corner_count);
		$display("and around multiples of pi), %0d sines checked under gaps and backpressure",
			sb.sines_checked);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/sta_pkg.sv
design/sta_horner_step.sv
design/sine_taylor_approximation.sv
verif/tb_top.sv
